### rtl/pwmcdf_pkg.sv
// PWM capture duty/frequency: shared types, constants and the microcode ROM.
// Used by pwmcdf_seq, pwmcdf_dp and pwm_capture_duty_frequency. No dependencies.
`timescale 1ns / 1ps

package pwmcdf_pkg;

  localparam int unsigned TICKS_MAX_DEF = 255;
  localparam logic [31:0] TIMER_HZ_RST  = 32'd1000000;
  localparam logic [14:0] DUTY_SCALE    = 15'd25600;
  localparam logic [15:0] DUTY_SAT      = 16'hFFFF;
  localparam int unsigned DIV_W         = 48;
  localparam logic [5:0]  DIV_STEPS     = 6'd48;
  localparam int unsigned STEP_W        = 4;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_WAIT      = 4'd0;
  localparam step_t S_CHK_TICK  = 4'd1;
  localparam step_t S_CHK_ZERO  = 4'd2;
  localparam step_t S_LD_DUTY   = 4'd3;
  localparam step_t S_DIV_DUTY  = 4'd4;
  localparam step_t S_ST_DUTY   = 4'd5;
  localparam step_t S_DIV_FREQ  = 4'd6;
  localparam step_t S_ST_FREQ   = 4'd7;
  localparam step_t S_CLR_HELD  = 4'd8;
  localparam step_t S_TICK      = 4'd9;
  localparam step_t S_EMIT      = 4'd10;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LD_DUTY,
    OP_DIV_STEP,
    OP_ST_DUTY,
    OP_ST_FREQ,
    OP_CLR_HELD,
    OP_TICK,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_TICK,
    C_PZERO,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic   take;
    dp_op_e op;
    cond_e  cond;
    step_t  target;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic is_tick;
    logic period_zero;
    logic div_more;
    logic out_busy;
  } status_t;

  function automatic ctl_t ucode_rom(input step_t step);
    ctl_t w;
    w = '{take: 1'b0, op: OP_NOP, cond: C_ALWAYS, target: S_WAIT};
    unique case (step)
      S_WAIT:     w = '{take: 1'b1, op: OP_NOP,      cond: C_NO_INPUT, target: S_WAIT};
      S_CHK_TICK: w = '{take: 1'b0, op: OP_NOP,      cond: C_TICK,     target: S_TICK};
      S_CHK_ZERO: w = '{take: 1'b0, op: OP_NOP,      cond: C_PZERO,    target: S_CLR_HELD};
      S_LD_DUTY:  w = '{take: 1'b0, op: OP_LD_DUTY,  cond: C_NEXT,     target: S_WAIT};
      S_DIV_DUTY: w = '{take: 1'b0, op: OP_DIV_STEP, cond: C_DIV_MORE, target: S_DIV_DUTY};
      S_ST_DUTY:  w = '{take: 1'b0, op: OP_ST_DUTY,  cond: C_NEXT,     target: S_WAIT};
      S_DIV_FREQ: w = '{take: 1'b0, op: OP_DIV_STEP, cond: C_DIV_MORE, target: S_DIV_FREQ};
      S_ST_FREQ:  w = '{take: 1'b0, op: OP_ST_FREQ,  cond: C_ALWAYS,   target: S_EMIT};
      S_CLR_HELD: w = '{take: 1'b0, op: OP_CLR_HELD, cond: C_ALWAYS,   target: S_EMIT};
      S_TICK:     w = '{take: 1'b0, op: OP_TICK,     cond: C_NEXT,     target: S_WAIT};
      S_EMIT:     w = '{take: 1'b0, op: OP_EMIT,     cond: C_OUT_BUSY, target: S_EMIT};
      default:    w = '{take: 1'b0, op: OP_NOP,      cond: C_ALWAYS,   target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

### rtl/pwmcdf_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on pwmcdf_pkg.
`timescale 1ns / 1ps

module pwmcdf_seq import pwmcdf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctl_t    ctl_o
);

  step_t step_q, step_d;
  ctl_t  ctl;
  logic  jump;

  always_comb begin
    ctl = ucode_rom(step_q);
  end

  always_comb begin
    case (ctl.cond)
      C_NEXT:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_INPUT: jump = !status_i.in_valid;
      C_TICK:     jump = status_i.is_tick;
      C_PZERO:    jump = status_i.period_zero;
      C_DIV_MORE: jump = status_i.div_more;
      C_OUT_BUSY: jump = status_i.out_busy;
      default:    jump = 1'b0;
    endcase
  end

  always_comb begin
    step_d = jump ? ctl.target : step_t'(step_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctl_o = ctl;

endmodule

### rtl/pwmcdf_dp.sv
// Datapath: input latch, duty multiplier, shared radix-2 divider, held values,
// staleness counter and output register. Depends on pwmcdf_pkg.
`timescale 1ns / 1ps

module pwmcdf_dp import pwmcdf_pkg::*; #(
  parameter int unsigned TicksMax = TICKS_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_t        ctl_i,
  input  logic        in_valid_i,
  input  logic        mode_i,
  input  logic [31:0] period_count_i,
  input  logic [31:0] high_count_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        out_stall_i,
  output status_t     status_o,
  output logic        out_valid_o,
  output logic [15:0] duty_percent_q8_o,
  output logic [39:0] frequency_hz_q8_o,
  output logic [7:0]  ticks_since_capture_o
);

  logic             mode_q;
  logic [31:0]      period_q, high_q;
  logic [31:0]      timer_hz_q;
  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [31:0]      rem_q, rem_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [15:0]      duty_q, duty_d;
  logic [39:0]      freq_q, freq_d;
  logic [7:0]       ticks_q, ticks_d;
  logic             out_valid_q, out_valid_d;
  logic [15:0]      out_duty_q;
  logic [39:0]      out_freq_q;
  logic [7:0]       out_ticks_q;
  logic [46:0]      duty_prod;
  logic [32:0]      trial;
  logic [32:0]      diff;
  logic             out_busy;
  logic             emit;

  assign duty_prod = 47'(high_q) * 47'(DUTY_SCALE);
  assign trial     = {rem_q, dvd_q[DIV_W-1]};
  assign diff      = trial - {1'b0, period_q};
  assign out_busy  = out_valid_q && out_stall_i;
  assign emit      = (ctl_i.op == OP_EMIT) && !out_busy;

  always_comb begin
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    duty_d  = duty_q;
    freq_d  = freq_q;
    ticks_d = ticks_q;
    unique case (ctl_i.op) inside
      OP_NOP, OP_EMIT: begin
      end
      OP_LD_DUTY: begin
        dvd_d = {1'b0, duty_prod};
        rem_d = '0;
        cnt_d = DIV_STEPS;
      end
      OP_DIV_STEP: begin
        // restoring step; quotient bits shift in behind the dividend
        if (!diff[32]) begin
          rem_d = diff[31:0];
          dvd_d = {dvd_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_d = trial[31:0];
          dvd_d = {dvd_q[DIV_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end
      OP_ST_DUTY: begin
        duty_d = (dvd_q[DIV_W-1:16] != '0) ? DUTY_SAT : dvd_q[15:0];
        dvd_d  = {8'b0, timer_hz_q, 8'b0};
        rem_d  = '0;
        cnt_d  = DIV_STEPS;
      end
      OP_ST_FREQ: begin
        freq_d  = dvd_q[39:0];
        ticks_d = '0;
      end
      OP_CLR_HELD: begin
        duty_d  = '0;
        freq_d  = '0;
        ticks_d = '0;
      end
      OP_TICK: begin
        if (ticks_q < 8'(TicksMax)) begin
          ticks_d = ticks_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_hz_q  <= TIMER_HZ_RST;
      duty_q      <= '0;
      freq_q      <= '0;
      ticks_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timer_hz_q <= cfg_data_i;
      end
      duty_q      <= duty_d;
      freq_q      <= freq_d;
      ticks_q     <= ticks_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take && in_valid_i) begin
      mode_q   <= mode_i;
      period_q <= period_count_i;
      high_q   <= high_count_i;
    end
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (emit) begin
      out_duty_q  <= duty_q;
      out_freq_q  <= freq_q;
      out_ticks_q <= ticks_q;
    end
  end

  assign status_o = '{
    in_valid:    in_valid_i,
    is_tick:     mode_q,
    period_zero: (period_q == '0),
    div_more:    (cnt_q != 6'd1),
    out_busy:    out_busy
  };

  assign out_valid_o           = out_valid_q;
  assign duty_percent_q8_o     = out_duty_q;
  assign frequency_hz_q8_o     = out_freq_q;
  assign ticks_since_capture_o = out_ticks_q;

  a_ticks_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ticks_q <= 8'(TicksMax))
    else $error("staleness counter above its maximum");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_DIV_STEP) |-> (cnt_q != '0))
    else $error("divider stepped with no steps left");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_busy |=> (out_valid_q && $stable(out_duty_q) && $stable(out_freq_q)
                  && $stable(out_ticks_q)))
    else $error("stalled result changed");

endmodule

### rtl/pwm_capture_duty_frequency.sv
// Top level of the PWM capture duty/frequency block: sequencer plus datapath.
// Depends on pwmcdf_pkg, pwmcdf_seq and pwmcdf_dp.
`timescale 1ns / 1ps

// One item at a time. A capture item passes two check steps, a load step that
// forms the duty product, two 48-step radix-2 divisions (duty, then frequency)
// on the one shared divider, each one quotient bit a cycle, a store step after
// each, and the emit step, which puts its result in the output register. A tick
// item passes the tick check, the tick step and the emit step; a zero-period
// capture passes both checks, the clear step and the emit step. After the emit
// step a spare step passes before the wait step takes the next item. A stalled
// result holds the next item at its emit step. The timer clock register may be
// written at any time the block is idle; it resets to 1 MHz.

module pwm_capture_duty_frequency import pwmcdf_pkg::*; #(
  parameter int unsigned TicksMax = TICKS_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] period_count_i,
  input  logic [31:0] high_count_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] timer_clock_hz_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] duty_percent_q8_o,
  output logic [39:0] frequency_hz_q8_o,
  output logic [7:0]  ticks_since_capture_o
);

  ctl_t    ctl;
  status_t status;

  pwmcdf_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctl_o    (ctl)
  );

  pwmcdf_dp #(
    .TicksMax (TicksMax)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .ctl_i                 (ctl),
    .in_valid_i            (in_valid_i),
    .mode_i                (mode_i),
    .period_count_i        (period_count_i),
    .high_count_i          (high_count_i),
    .cfg_we_i              (cfg_valid_i && cfg_ready_o),
    .cfg_data_i            (timer_clock_hz_i),
    .out_stall_i           (out_stall_i),
    .status_o              (status),
    .out_valid_o           (out_valid_o),
    .duty_percent_q8_o     (duty_percent_q8_o),
    .frequency_hz_q8_o     (frequency_hz_q8_o),
    .ticks_since_capture_o (ticks_since_capture_o)
  );

  assign in_stall_o  = !ctl.take;
  assign cfg_ready_o = 1'b1;

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken twice without a result in between");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result loaded while waiting for input");

  a_out_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ticks_since_capture_o <= 8'(TicksMax)))
    else $error("reported tick count above its maximum");

endmodule

### bench/pwmcdf_tb_pkg.sv
// Bench-side codes for the PWM capture duty/frequency testbench.
// Used by the checker and the testbench top. No dependencies.
`timescale 1ns / 1ps

package pwmcdf_tb_pkg;

  localparam logic MODE_CAPTURE = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

endpackage

### bench/pwm_capture_duty_frequency_chk.sv
// Checker for pwm_capture_duty_frequency: tracks the held readings and compares results.
// Depends on pwmcdf_pkg (constants) and pwmcdf_tb_pkg (item codes).
`timescale 1ns / 1ps

module pwm_capture_duty_frequency_chk
  import pwmcdf_pkg::*;
  import pwmcdf_tb_pkg::*;
#(
  parameter int unsigned TicksMax = TICKS_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        mode_i,
  input  logic [31:0] period_count_i,
  input  logic [31:0] high_count_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] timer_clock_hz_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] duty_percent_q8_i,
  input  logic [39:0] frequency_hz_q8_i,
  input  logic [7:0]  ticks_since_capture_i,
  output int          mismatch_count_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct packed {
    logic [15:0] duty;
    logic [39:0] freq;
    logic [7:0]  ticks;
  } reading_t;

  reading_t    readings_q[$];
  logic [31:0] timer_hz;
  logic [15:0] duty_hold;
  logic [39:0] freq_hold;
  logic [7:0]  stale_cnt;

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    mismatch_count_o++;
    if (mismatch_count_o <= 40) begin
      $display("%0t ns: %s got %0h, want %0h", $time, what, got, want);
    end
  endtask

  task automatic take_reading(input logic mode, input logic [31:0] period,
                              input logic [31:0] high);
    logic [63:0] duty_full;
    if (mode == MODE_CAPTURE) begin
      if (period == '0) begin
        duty_hold = '0;
        freq_hold = '0;
      end else begin
        duty_full = (64'(high) * 64'(DUTY_SCALE)) / 64'(period);
        duty_hold = (duty_full > 64'(DUTY_SAT)) ? DUTY_SAT : duty_full[15:0];
        freq_hold = 40'((64'(timer_hz) << 8) / 64'(period));
      end
      stale_cnt = '0;
    end else if (stale_cnt < 8'(TicksMax)) begin
      stale_cnt = stale_cnt + 8'd1;
    end
    readings_q.push_back('{duty: duty_hold, freq: freq_hold, ticks: stale_cnt});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      timer_hz         = TIMER_HZ_RST;
      duty_hold        = '0;
      freq_hold        = '0;
      stale_cnt        = '0;
      mismatch_count_o = 0;
      checked_o        = 0;
      readings_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        timer_hz = timer_clock_hz_i;
      end
      if (in_valid_i && !in_stall_i) begin
        take_reading(mode_i, period_count_i, high_count_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (readings_q.size() == 0) begin
          report_mismatch("result with nothing pending, duty", 40'(duty_percent_q8_i), '0);
        end else begin
          want = readings_q.pop_front();
          checked_o++;
          if (duty_percent_q8_i != want.duty) begin
            report_mismatch("duty_percent_q8", 40'(duty_percent_q8_i), 40'(want.duty));
          end
          if (frequency_hz_q8_i != want.freq) begin
            report_mismatch("frequency_hz_q8", frequency_hz_q8_i, want.freq);
          end
          if (ticks_since_capture_i != want.ticks) begin
            report_mismatch("ticks_since_capture", 40'(ticks_since_capture_i),
                            40'(want.ticks));
          end
        end
      end
    end
    pending_o = readings_q.size();
  end

endmodule

### bench/tb_pwm_capture_duty_frequency.sv
// Testbench top for pwm_capture_duty_frequency: stimulus, stalls and the verdict.
// Depends on pwmcdf_pkg, pwmcdf_tb_pkg, the block and pwm_capture_duty_frequency_chk.
`timescale 1ns / 1ps

module tb_pwm_capture_duty_frequency;
  import pwmcdf_pkg::*;
  import pwmcdf_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned PHASE_ITEMS   = 170;
  localparam int unsigned TICK_RUN      = 270;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic        mode_i           = MODE_CAPTURE;
  logic [31:0] period_count_i   = '0;
  logic [31:0] high_count_i     = '0;
  logic        cfg_valid_i      = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] timer_clock_hz_i = '0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [15:0] duty_percent_q8_o;
  logic [39:0] frequency_hz_q8_o;
  logic [7:0]  ticks_since_capture_o;

  int mismatches;
  int pending;
  int checked;
  int n_capture   = 0;
  int n_tick      = 0;
  int n_cfg       = 0;
  int cycle_cnt   = 0;
  bit calm        = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_served = 1'b0;

  always #4 clk_i = ~clk_i;

  pwm_capture_duty_frequency i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .mode_i                (mode_i),
    .period_count_i        (period_count_i),
    .high_count_i          (high_count_i),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .timer_clock_hz_i      (timer_clock_hz_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .duty_percent_q8_o     (duty_percent_q8_o),
    .frequency_hz_q8_o     (frequency_hz_q8_o),
    .ticks_since_capture_o (ticks_since_capture_o)
  );

  pwm_capture_duty_frequency_chk i_chk (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_i            (in_stall_o),
    .mode_i                (mode_i),
    .period_count_i        (period_count_i),
    .high_count_i          (high_count_i),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_i           (cfg_ready_o),
    .timer_clock_hz_i      (timer_clock_hz_i),
    .out_valid_i           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .duty_percent_q8_i     (duty_percent_q8_o),
    .frequency_hz_q8_i     (frequency_hz_q8_o),
    .ticks_since_capture_i (ticks_since_capture_o),
    .mismatch_count_o      (mismatches),
    .pending_o             (pending),
    .checked_o             (checked)
  );

  // Entered and left at a falling edge; valid stays high between back-to-back items.
  task automatic send_item(input logic mode, input logic [31:0] period,
                           input logic [31:0] high);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    period_count_i <= period;
    high_count_i   <= high;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (mode == MODE_TICK) n_tick++;
    else n_capture++;
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_timer_hz(input logic [31:0] hz);
    cfg_valid_i      <= 1'b1;
    timer_clock_hz_i <= hz;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    n_cfg++;
  endtask

  function automatic logic [31:0] pick_period_count();
    case ($urandom_range(0, 9)) inside
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3, 4:    return $urandom_range(1, 255);
      5, 6:    return $urandom_range(256, 65535);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_high_count(input logic [31:0] period);
    case ($urandom_range(0, 9)) inside
      0:          return '0;
      1:          return '1;
      2:          return period;
      3:          return period + $urandom_range(1, 1000);
      4, 5, 6:    return 32'($urandom() % (64'(period) + 64'd1));
      default:    return $urandom();
    endcase
  endfunction

  task automatic random_phase(input int n_items);
    int          sent;
    int          run;
    logic [31:0] period;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 3) begin
        run = $urandom_range(1, 12);
        repeat (run) send_item(MODE_TICK, $urandom(), $urandom());
        sent += run;
      end else begin
        period = pick_period_count();
        send_item(MODE_CAPTURE, period, pick_high_count(period));
        sent++;
      end
    end
    drain_block();
  endtask

  // Output side: random stall bursts, one long hold-off, none in the calm tail.
  initial begin
    int burst;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (calm) begin
        out_stall_i <= 1'b0;
      end else if (hold_req && !hold_served) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_served = 1'b1;
      end else begin
        burst = $urandom_range(1, 11);
        out_stall_i <= ($urandom_range(0, 2) == 0);
        repeat (burst - 1) @(negedge clk_i);
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("no finish within %0d cycles", CYCLE_LIMIT);
    $display("pwm_capture_duty_frequency: mismatch");
    $finish;
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, timer clock at its reset value
    send_item(MODE_CAPTURE, 32'd0, 32'd0);
    send_item(MODE_CAPTURE, 32'd0, '1);
    send_item(MODE_TICK, 32'd0, 32'd0);
    send_item(MODE_CAPTURE, 32'd1, 32'd0);
    send_item(MODE_CAPTURE, 32'd1, 32'd1);
    send_item(MODE_CAPTURE, 32'd1, '1);
    send_item(MODE_CAPTURE, '1, '1);
    send_item(MODE_CAPTURE, '1, 32'd0);
    send_item(MODE_CAPTURE, 32'd100, 32'd50);
    send_item(MODE_CAPTURE, 32'd3, 32'd7);
    send_item(MODE_CAPTURE, 32'd25600, 32'd1);
    send_item(MODE_CAPTURE, 32'd25601, 32'd1);
    send_item(MODE_TICK, '1, '1);
    send_item(MODE_TICK, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(MODE_CAPTURE, 32'hAAAA_AAAA, 32'h5555_5555);
    send_item(MODE_CAPTURE, 32'h5555_5555, 32'hAAAA_AAAA);
    drain_block();

    // full-scale timer clock
    write_timer_hz('1);
    send_item(MODE_CAPTURE, 32'd1, 32'd1);
    send_item(MODE_CAPTURE, '1, 32'd0);
    send_item(MODE_CAPTURE, 32'd0, 32'd5);
    send_item(MODE_TICK, 32'd0, 32'd0);
    hold_req = 1'b1;
    random_phase(PHASE_ITEMS);

    // slowest timer clock, then a tick run past the counter limit
    write_timer_hz(32'd1);
    repeat (TICK_RUN) send_item(MODE_TICK, $urandom(), $urandom());
    random_phase(PHASE_ITEMS);

    write_timer_hz($urandom());
    random_phase(PHASE_ITEMS);
    write_timer_hz(32'd50_000_000);
    random_phase(PHASE_ITEMS);
    write_timer_hz($urandom());
    random_phase(PHASE_ITEMS);

    calm = 1'b1;
    write_timer_hz(TIMER_HZ_RST);
    random_phase(PHASE_ITEMS);

    $display("%0d captures and %0d ticks sent over %0d timer clock writes, %0d results checked",
             n_capture, n_tick, n_cfg, checked);
    $display("zero and full-scale counts, both saturations and a %0d-cycle hold-off",
             LONG_HOLD);
    if (mismatches == 0) begin
      $display("pwm_capture_duty_frequency: match");
    end else begin
      $display("pwm_capture_duty_frequency: mismatch");
    end
    $finish;
  end

endmodule
